@@ sv/qvla_pkg.sv @@
// Shared types and constants of the quorum vote lock arbiter.
package qvla_pkg;

    // Fixed field widths
    localparam int NODE_W = 4;
    localparam int MODE_W = 2;
    localparam int KIND_W = 2;
    localparam int GRANT_W = 4;

    // Node ids at or above this bound are ignored
    localparam int MAX_NODES = 16;

    // Default depth of the waiting queue
    localparam int QUEUE_DEPTH_DEF = 16;

    // Input modes
    localparam logic [MODE_W-1:0] MODE_LOCAL_REQ = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PEER_REQ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GRANT     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 2'd3;

    // Outgoing message kinds
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOCK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Configuration register indexes
    localparam logic CFG_OWN_NODE_ID = 1'b0;
    localparam logic CFG_QUORUM_SIZE = 1'b1;

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0] message_kind;
        logic              to_all;
        logic [NODE_W-1:0] target_node;
        logic              queue_overflow;
        logic              last_of_run;
    } res_t;

    // What the vote controller hands to the output side
    typedef struct packed {
        logic push;
        res_t res;
        logic busy;
    } ctrl_out_t;

endpackage

@@ sv/quorum_vote_lock_arbiter.sv @@
// Quorum vote lock arbiter: one voting node of a quorum lock with output buffer.
// A result word, where the input word yields one, is written to the output buffer as
// the input word is accepted; a LOCK handed to the queue head follows in the POP state,
// after the wait-queue memory read. Up to one input word per cycle while the output
// buffer has room; no input is taken in the POP state, which reads the wait-queue memory.
// Reset clears the vote, queue pointers, grant counter and output buffer pointers; the queue
// memory contents are left unset and need no clearing pass.
module quorum_vote_lock_arbiter
    import qvla_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [NODE_W-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,  // mode[1:0], source_node[5:2], zero[7:6]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,  // message_kind[1:0], to_all[2],
                                             // target_node[6:3], queue_overflow[7]
    output logic              m_axis_tlast
);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    logic [NODE_W-1:0]  own_node_id_reg;
    logic [GRANT_W-1:0] quorum_size_reg;
    ctrl_out_t          ctrl;
    logic               in_accept;
    logic               out_pop;

    res_t               out_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] out_wr_reg;
    logic [OUT_PTR_W-1:0] out_rd_reg;
    logic [OUT_CNT_W-1:0] out_count_reg, out_count_next;
    res_t               out_word;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_id_reg <= '0;
            quorum_size_reg <= GRANT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OWN_NODE_ID: own_node_id_reg <= cfg_data;
                CFG_QUORUM_SIZE: quorum_size_reg <= cfg_data;
                default:         own_node_id_reg <= own_node_id_reg;
            endcase
        end
    end

    // Input is taken while the controller is free and the buffer has room for two words
    assign s_axis_tready = !ctrl.busy && (out_count_reg <= OUT_CNT_W'(OUT_DEPTH - 2));
    assign in_accept = s_axis_tvalid && s_axis_tready;

    qvla_vote_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_vote_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .in_mode     (s_axis_tdata[1:0]),
        .in_source   (s_axis_tdata[5:2]),
        .own_node_id (own_node_id_reg),
        .quorum_size (quorum_size_reg),
        .ctrl        (ctrl)
    );

    // Output buffer storage
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            out_mem[out_wr_reg] <= ctrl.res;
        end
    end

    assign out_pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        out_count_next = out_count_reg;
        if (ctrl.push && !out_pop)
        begin
            out_count_next = out_count_reg + OUT_CNT_W'(1);
        end
        else if (!ctrl.push && out_pop)
        begin
            out_count_next = out_count_reg - OUT_CNT_W'(1);
        end
    end

    // Output buffer pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg <= '0;
            out_rd_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (ctrl.push)
            begin
                out_wr_reg <= out_wr_reg + OUT_PTR_W'(1);
            end
            if (out_pop)
            begin
                out_rd_reg <= out_rd_reg + OUT_PTR_W'(1);
            end
            out_count_reg <= out_count_next;
        end
    end

    // Result word to the master side
    assign out_word = out_mem[out_rd_reg];
    assign m_axis_tvalid = (out_count_reg != '0);
    assign m_axis_tdata = {out_word.queue_overflow, out_word.target_node,
                           out_word.to_all, out_word.message_kind};
    assign m_axis_tlast = out_word.last_of_run;

`ifndef SYNTH
    // The output buffer never overfills.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("output buffer overfilled");

    // A cycle spent on a queue read always delivers the LOCK word.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.busy |-> ctrl.push)
        else $error("queue read gave no LOCK word");

    // An own request always yields its REQUEST broadcast at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tdata[1:0] == MODE_LOCAL_REQ)) |->
        (ctrl.push && ctrl.res.to_all && (ctrl.res.message_kind == KIND_REQUEST)))
        else $error("own request without broadcast");

    // A two-word run is followed by its second word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push && !ctrl.res.last_of_run) |=> (ctrl.push && ctrl.res.last_of_run))
        else $error("run left unfinished");
`endif

endmodule

@@ sv/qvla_wait_ram.sv @@
// Synchronous memory holding the ids of nodes waiting for the vote.
module qvla_wait_ram
    import qvla_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int PTR_W = 4
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [PTR_W-1:0]  waddr,
    input  logic [NODE_W-1:0] wdata,
    input  logic              re,
    input  logic [PTR_W-1:0]  raddr,
    output logic [NODE_W-1:0] rdata
);

    logic [NODE_W-1:0] mem [QUEUE_DEPTH];
    logic [NODE_W-1:0] rdata_reg;

    // One write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/qvla_vote_ctrl.sv @@
// Vote state, queue pointers and grant counter of the arbiter.
module qvla_vote_ctrl
    import qvla_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  logic [MODE_W-1:0]  in_mode,
    input  logic [NODE_W-1:0]  in_source,
    input  logic [NODE_W-1:0]  own_node_id,
    input  logic [GRANT_W-1:0] quorum_size,
    output ctrl_out_t          ctrl
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = FILL_W + 1;
    localparam int SRC_CMP_W = 9;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic               state_reg, state_next;
    logic               vote_taken_reg, vote_taken_next;
    logic [NODE_W-1:0]  vote_holder_reg, vote_holder_next;
    logic [PTR_W-1:0]   queue_head_reg, queue_head_next;
    logic [FILL_W-1:0]  queue_fill_reg, queue_fill_next;
    logic [GRANT_W-1:0] grants_seen_reg, grants_seen_next;

    logic               ram_we;
    logic [NODE_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [NODE_W-1:0]  ram_rdata;
    logic [SUM_W-1:0]   wr_sum;
    logic [PTR_W-1:0]   wr_addr;
    logic [PTR_W-1:0]   head_inc;
    logic               queue_full;
    logic               queue_empty;
    logic               src_ok;
    logic               src_holds;
    logic               own_holds;
    logic [GRANT_W-1:0] grants_inc;
    logic               push;
    res_t               res;

    qvla_wait_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W)
    ) u_wait_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (queue_head_reg),
        .rdata (ram_rdata)
    );

    // Queue arithmetic: tail slot, next head, full and empty
    always_comb
    begin
        wr_sum = SUM_W'(queue_head_reg) + SUM_W'(queue_fill_reg);
        if (wr_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            wr_addr = PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH));
        end
        else
        begin
            wr_addr = PTR_W'(wr_sum);
        end
        if (queue_head_reg == PTR_W'(QUEUE_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = queue_head_reg + PTR_W'(1);
        end
        queue_full = (queue_fill_reg == FILL_W'(QUEUE_DEPTH));
        queue_empty = (queue_fill_reg == '0);
    end

    // Message decode helpers
    assign src_ok = (SRC_CMP_W'(in_source) < SRC_CMP_W'(MAX_NODES));
    assign src_holds = vote_taken_reg && (in_source == vote_holder_reg);
    assign own_holds = vote_taken_reg && (own_node_id == vote_holder_reg);
    assign grants_inc = grants_seen_reg + GRANT_W'(1);

    // Read-modify-write of the vote state; a pass to the queue head goes through
    // the POP state for the memory read.
    always_comb
    begin
        state_next = state_reg;
        vote_taken_next = vote_taken_reg;
        vote_holder_next = vote_holder_reg;
        queue_head_next = queue_head_reg;
        queue_fill_next = queue_fill_reg;
        grants_seen_next = grants_seen_reg;
        ram_we = 1'b0;
        ram_wdata = own_node_id;
        ram_re = 1'b0;
        push = 1'b0;
        res = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_mode == MODE_LOCAL_REQ))
                begin
                    // Own request: broadcast, then take the vote, queue up, or flag a queue overflow
                    push = 1'b1;
                    res.message_kind = KIND_REQUEST;
                    res.to_all = 1'b1;
                    res.last_of_run = 1'b1;
                    if (!vote_taken_reg)
                    begin
                        vote_taken_next = 1'b1;
                        vote_holder_next = own_node_id;
                    end
                    else if (!queue_full)
                    begin
                        ram_we = 1'b1;
                        queue_fill_next = queue_fill_reg + FILL_W'(1);
                    end
                    else
                    begin
                        res.queue_overflow = 1'b1;
                    end
                end
                else if (in_accept && src_ok)
                begin
                    case (in_mode)
                        MODE_PEER_REQ:
                        begin
                            if (!vote_taken_reg)
                            begin
                                vote_taken_next = 1'b1;
                                vote_holder_next = in_source;
                                push = 1'b1;
                                res.message_kind = KIND_LOCK;
                                res.target_node = in_source;
                                res.last_of_run = 1'b1;
                            end
                            else if (!src_holds)
                            begin
                                if (!queue_full)
                                begin
                                    ram_we = 1'b1;
                                    ram_wdata = in_source;
                                    queue_fill_next = queue_fill_reg + FILL_W'(1);
                                end
                                else
                                begin
                                    push = 1'b1;
                                    res.message_kind = KIND_REQUEST;
                                    res.target_node = in_source;
                                    res.queue_overflow = 1'b1;
                                    res.last_of_run = 1'b1;
                                end
                            end
                        end
                        MODE_GRANT:
                        begin
                            grants_seen_next = grants_inc;
                            if (grants_inc == quorum_size)
                            begin
                                grants_seen_next = '0;
                                push = 1'b1;
                                res.message_kind = KIND_RELEASE;
                                res.to_all = 1'b1;
                                res.last_of_run = 1'b1;
                                if (own_holds)
                                begin
                                    if (!queue_empty)
                                    begin
                                        ram_re = 1'b1;
                                        state_next = S_POP;
                                        res.last_of_run = 1'b0;
                                    end
                                    else
                                    begin
                                        vote_taken_next = 1'b0;
                                        vote_holder_next = '0;
                                    end
                                end
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (src_holds)
                            begin
                                if (!queue_empty)
                                begin
                                    ram_re = 1'b1;
                                    state_next = S_POP;
                                end
                                else
                                begin
                                    vote_taken_next = 1'b0;
                                    vote_holder_next = '0;
                                end
                            end
                        end
                        default:
                        begin
                            vote_taken_next = vote_taken_reg;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                // Queue head arrives from memory: it takes the vote
                vote_taken_next = 1'b1;
                vote_holder_next = ram_rdata;
                queue_head_next = head_inc;
                queue_fill_next = queue_fill_reg - FILL_W'(1);
                push = 1'b1;
                res.message_kind = KIND_LOCK;
                res.target_node = ram_rdata;
                res.last_of_run = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vote_taken_reg <= 1'b0;
            vote_holder_reg <= '0;
            queue_head_reg <= '0;
            queue_fill_reg <= '0;
            grants_seen_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            vote_taken_reg <= vote_taken_next;
            vote_holder_reg <= vote_holder_next;
            queue_head_reg <= queue_head_next;
            queue_fill_reg <= queue_fill_next;
            grants_seen_reg <= grants_seen_next;
        end
    end

    assign ctrl.push = push;
    assign ctrl.res = res;
    assign ctrl.busy = (state_reg == S_POP);

endmodule
